// ----- hw/rtl/lwr_pkg.sv -----
// Shared types and constants for the LWMA difficulty retarget unit.
`default_nettype none

package lwr_pkg;

    // Counter widths
    localparam int CNT_W    = 9;
    localparam int SZ_W     = 6;

    // Fixed iteration counts
    localparam logic [CNT_W-1:0] DIV_LAST = 9'd255;
    localparam logic [CNT_W-1:0] MUL_LAST = 9'd16;
    localparam logic [SZ_W-1:0]  SZ_FULL  = 6'd32;

    // Configuration register indexes
    localparam logic [2:0] REG_SPACING = 3'd0;
    localparam logic [2:0] REG_MIN_WIN = 3'd1;
    localparam logic [2:0] REG_LIMIT0  = 3'd2;
    localparam logic [2:0] REG_LIMIT1  = 3'd3;
    localparam logic [2:0] REG_LIMIT2  = 3'd4;
    localparam logic [2:0] REG_LIMIT3  = 3'd5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;
        logic expand;
        logic accum;
        logic prep;
        logic kt;
        logic div_init;
        logic div_sel;
        logic div_step;
        logic mul_init;
        logic mul_step;
        logic clamp;
        logic scan_step;
        logic pack;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;
        logic short_win;
        logic div_last;
        logic mul_last;
        logic scan_stop;
        logic out_busy;
    } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lwr_ctrl.sv -----
// Sequencing state machine for the LWMA difficulty retarget unit.
`default_nettype none

module lwr_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire lwr_pkg::sts_t  sts,
    output lwr_pkg::cmd_t       cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EXP  = 4'd1;
    localparam logic [3:0] S_ACC  = 4'd2;
    localparam logic [3:0] S_PREP = 4'd3;
    localparam logic [3:0] S_KT   = 4'd4;
    localparam logic [3:0] S_D1I  = 4'd5;
    localparam logic [3:0] S_D1   = 4'd6;
    localparam logic [3:0] S_MI   = 4'd7;
    localparam logic [3:0] S_MUL  = 4'd8;
    localparam logic [3:0] S_D2I  = 4'd9;
    localparam logic [3:0] S_D2   = 4'd10;
    localparam logic [3:0] S_CL   = 4'd11;
    localparam logic [3:0] S_SC   = 4'd12;
    localparam logic [3:0] S_PK   = 4'd13;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXP;
                end
            end
            S_EXP:
            begin
                cmd.expand = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.accum  = 1'b1;
                state_next = sts.last ? S_PREP : S_IDLE;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_KT;
            end
            S_KT:
            begin
                cmd.kt     = 1'b1;
                state_next = sts.short_win ? S_PK : S_D1I;
            end
            S_D1I:
            begin
                cmd.div_init = 1'b1;
                state_next   = S_D1;
            end
            S_D1:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_MI;
                end
            end
            S_MI:
            begin
                cmd.mul_init = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (sts.mul_last)
                begin
                    state_next = S_D2I;
                end
            end
            S_D2I:
            begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = 1'b1;
                state_next   = S_D2;
            end
            S_D2:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_CL;
                end
            end
            S_CL:
            begin
                cmd.clamp  = 1'b1;
                state_next = S_SC;
            end
            S_SC:
            begin
                if (sts.scan_stop)
                begin
                    state_next = S_PK;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_PK:
            begin
                if (!sts.out_busy)
                begin
                    cmd.pack   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lwr_dp.sv -----
// Datapath: accumulators, shared divider, multiplier, compact encoder, output register.
`default_nettype none

module lwr_dp #(
    parameter int MAX_WINDOW = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire lwr_pkg::cmd_t  cmd,
    output lwr_pkg::sts_t       sts,
    input  wire [31:0]          header_time,
    input  wire [31:0]          header_bits,
    input  wire                 last_header,
    input  wire                 cfg_we,
    input  wire [2:0]           cfg_index,
    input  wire [63:0]          cfg_data,
    input  wire                 out_ready,
    output logic                out_valid,
    output logic [31:0]         next_bits,
    output logic                status
);

    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int MW   = (CW > 7) ? CW : 7;
    localparam int KW   = 2 * CW;
    localparam int PW   = CW + 19;
    localparam logic [CW-1:0] MAXC = CW'(MAX_WINDOW);

    // Configuration registers
    logic [15:0]  spacing_reg;
    logic [6:0]   min_win_reg;
    logic [255:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= 16'd60;
            min_win_reg <= 7'd45;
            limit_reg   <= {64'h0000_0000_FFFF_FFFF, {192{1'b1}}};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lwr_pkg::REG_SPACING: spacing_reg <= cfg_data[15:0];
                lwr_pkg::REG_MIN_WIN: min_win_reg <= cfg_data[6:0];
                lwr_pkg::REG_LIMIT0:  limit_reg[63:0]    <= cfg_data;
                lwr_pkg::REG_LIMIT1:  limit_reg[127:64]  <= cfg_data;
                lwr_pkg::REG_LIMIT2:  limit_reg[191:128] <= cfg_data;
                lwr_pkg::REG_LIMIT3:  limit_reg[255:192] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input holding and per-header stage registers
    logic [31:0]     time_reg;
    logic [31:0]     bits_reg;
    logic            last_reg;
    logic [255:0]    exp_reg;
    logic [PW-1:0]   prod_reg;

    // Window state
    logic [31:0]     prev_reg;
    logic [CW-1:0]   count_reg;
    logic [63:0]     ws_reg;
    logic [255:0]    sum_reg;

    // Finish-phase registers
    logic            short_reg;
    logic [KW-1:0]   k_reg;
    logic [63:0]     kt_reg;
    logic [255:0]    dq_reg;
    logic [63:0]     rem_reg;
    logic [63:0]     dvs_reg;
    logic [8:0]      cnt_reg;
    logic [63:0]     pp_reg;
    logic [3:0]      sh_reg;
    logic [255:0]    acc_reg;
    logic [255:0]    val_reg;
    logic [5:0]      sz_reg;

    // Output registers
    logic            out_valid_reg;
    logic [31:0]     next_bits_reg;
    logic            status_reg;

    // Solvetime clamp and target expansion
    logic [31:0]     st_raw;
    logic [18:0]     st_hi;
    logic [18:0]     st;
    logic [7:0]      exp_size;
    logic [255:0]    exp_val;

    always_comb
    begin
        st_raw   = (time_reg >= prev_reg) ? (time_reg - prev_reg) : 32'd0;
        st_hi    = 19'(spacing_reg) * 19'd6;
        if (st_raw < 32'd1)
        begin
            st_raw = 32'd1;
        end
        st       = (st_raw > 32'(st_hi)) ? st_hi : st_raw[18:0];
        exp_size = bits_reg[31:24];
        if (exp_size <= 8'd3)
        begin
            exp_val = 256'(bits_reg[22:0] >> {(2'd3 - exp_size[1:0]), 3'b000});
        end
        else
        begin
            exp_val = {233'b0, bits_reg[22:0]} << {(exp_size - 8'd3), 3'b000};
        end
    end

    // Restoring divide step: one quotient bit per cycle
    logic [63:0]     rem_sh;
    logic            rem_top;
    logic            q_bit;

    always_comb
    begin
        rem_top = rem_reg[63];
        rem_sh  = {rem_reg[62:0], dq_reg[255]};
        q_bit   = rem_top || (rem_sh >= dvs_reg);
    end

    // Byte scan and compact encoding
    logic [4:0]      scan_idx;
    logic [7:0]      scan_byte;
    logic [31:0]     cmp_c;
    logic [7:0]      cmp_size;
    logic [31:0]     cmp_bits;

    always_comb
    begin
        scan_idx  = 5'(sz_reg - 6'd1);
        scan_byte = val_reg[{scan_idx, 3'b000} +: 8];
        cmp_size  = 8'(sz_reg);
        if (sz_reg <= 6'd3)
        begin
            cmp_c = val_reg[31:0] << {(2'd3 - sz_reg[1:0]), 3'b000};
        end
        else
        begin
            cmp_c = 32'(val_reg >> {(sz_reg - 6'd3), 3'b000});
        end
        if (cmp_c[23])
        begin
            cmp_c    = cmp_c >> 8;
            cmp_size = cmp_size + 8'd1;
        end
        cmp_bits = {cmp_size, cmp_c[23:0]};
    end

    // Header accumulation and window clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            count_reg <= '0;
            ws_reg    <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.pack)
        begin
            prev_reg  <= '0;
            count_reg <= '0;
            ws_reg    <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.accum && (count_reg < MAXC))
        begin
            ws_reg    <= ws_reg + 64'(prod_reg);
            sum_reg   <= sum_reg + exp_reg;
            prev_reg  <= time_reg;
            count_reg <= count_reg + CW'(1);
        end
    end

    // Payload registers of the header and finish phases
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            time_reg <= header_time;
            bits_reg <= header_bits;
            last_reg <= last_header;
        end
        if (cmd.expand)
        begin
            exp_reg  <= exp_val;
            prod_reg <= PW'(count_reg) * PW'(st);
        end
        if (cmd.prep)
        begin
            short_reg <= (MW'(count_reg) < MW'(min_win_reg));
            k_reg     <= ((KW'(count_reg) * KW'(count_reg - CW'(1))) >> 1) == '0
                         ? KW'(1)
                         : (KW'(count_reg) * KW'(count_reg - CW'(1))) >> 1;
        end
        if (cmd.kt)
        begin
            kt_reg <= 64'(k_reg * (KW + 16)'(spacing_reg));
        end
        if (cmd.div_init)
        begin
            dq_reg  <= cmd.div_sel ? acc_reg : sum_reg;
            dvs_reg <= cmd.div_sel ? kt_reg : 64'(count_reg);
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dq_reg  <= {dq_reg[254:0], q_bit};
            rem_reg <= q_bit ? (rem_sh - dvs_reg) : rem_sh;
            cnt_reg <= cnt_reg + 9'd1;
        end
        else if (cmd.mul_init)
        begin
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (cnt_reg < lwr_pkg::MUL_LAST)
            begin
                pp_reg <= 64'(dq_reg[{cnt_reg[3:1], 5'b00000} +: 32])
                        * 64'(ws_reg[{cnt_reg[0], 5'b00000} +: 32]);
                sh_reg <= 4'(cnt_reg[3:1]) + 4'(cnt_reg[0]);
            end
            if (cnt_reg != '0)
            begin
                acc_reg <= acc_reg + ({192'b0, pp_reg} << {sh_reg, 5'b00000});
            end
            cnt_reg <= cnt_reg + 9'd1;
        end
        if (cmd.clamp)
        begin
            val_reg <= (dq_reg > limit_reg) ? limit_reg : dq_reg;
            sz_reg  <= lwr_pkg::SZ_FULL;
        end
        else if (cmd.scan_step)
        begin
            sz_reg <= sz_reg - 6'd1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.pack)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pack)
        begin
            next_bits_reg <= short_reg ? 32'd0 : cmp_bits;
            status_reg    <= short_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign next_bits = next_bits_reg;
    assign status    = status_reg;

    // Status to the controller
    always_comb
    begin
        sts.last      = last_reg;
        sts.short_win = short_reg;
        sts.div_last  = (cnt_reg == lwr_pkg::DIV_LAST);
        sts.mul_last  = (cnt_reg == lwr_pkg::MUL_LAST);
        sts.scan_stop = (sz_reg == 6'd0) || (scan_byte != 8'd0);
        sts.out_busy  = out_valid_reg && !out_ready;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lwma_difficulty_retarget_unit.sv -----
// Top level of the LWMA difficulty retarget unit.
//
// Headers of a window enter on the s_ stream, oldest first; s_tlast marks the
// last header of the window. One result item leaves on the m_ stream for each
// window: m_tdata carries the next compact target and m_tuser the status
// (1 when the window held fewer than min_window headers).
// A header that does not close the window is accepted, expanded and accumulated.
// A closing header of a long enough window then runs two 256-step restoring divides
// in the shared divider, a 32x32 partial-product multiply and a byte scan for the
// encoder. A closing header of a short window skips the divides, multiply and scan.
// Only one item is worked on at a time; s_tready is high while the unit waits.
// The result sits in an output register; if the receiver stalls, the unit can
// still take and accumulate headers, and holds only when a new result is ready
// while the old one is still waiting.
// Configuration is to be written through cfg_we/cfg_index/cfg_data while idle;
// the unit does not enforce this. Reset clears the window and loads the default
// configuration; no result is pending after reset.
`default_nettype none

module lwma_difficulty_retarget_unit #(
    parameter int MAX_WINDOW = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [63:0]  s_tdata,   // header_time [31:0], header_bits [63:32]
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // next_bits [31:0]
    output logic        m_tuser,   // status [0]
    input  wire         cfg_we,
    input  wire [2:0]   cfg_index,
    input  wire [63:0]  cfg_data
);

    lwr_pkg::cmd_t cmd;
    lwr_pkg::sts_t sts;

    lwr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lwr_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .header_time (s_tdata[31:0]),
        .header_bits (s_tdata[63:32]),
        .last_header (s_tlast),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .next_bits   (m_tdata),
        .status      (m_tuser)
    );

    // The datapath runs at most one operation at a time.
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.expand, cmd.accum, cmd.div_step, cmd.mul_step, cmd.scan_step, cmd.pack}))
        else $error("more than one datapath operation at once");

    // An error result always carries a zero target.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 32'd0))
        else $error("error result with nonzero target");

    // After an item is taken, the unit is busy in the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted on consecutive cycles");

endmodule

`default_nettype wire

// ----- tb/lwma_retarget_checker.sv -----
// Checker for the LWMA retarget unit: predicts each window's result and compares it.
`default_nettype none

module lwma_retarget_checker (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire [63:0]  s_tdata,   // header_time [31:0], header_bits [63:32]
    input  wire         s_tlast,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire [31:0]  m_tdata,   // next_bits [31:0]
    input  wire         m_tuser,   // status [0]
    input  wire         cfg_we,
    input  wire [2:0]   cfg_index,
    input  wire [63:0]  cfg_data,
    output int          fail_count,
    output int          pending
);

    localparam int WINDOW_CAP = 64;

    typedef struct packed {
        logic [31:0] next_bits;
        logic        status;
    } retarget_t;

    // Shadow configuration
    logic [15:0]  spacing;
    logic [6:0]   min_headers;
    logic [255:0] limit;

    // Shadow window state
    logic [31:0]  prev_time;
    logic [6:0]   count;
    logic [63:0]  weighted_st;
    logic [255:0] target_total;

    retarget_t retarget_q[$];

    assign pending = retarget_q.size();

    // Expand a compact nBits value to a 256-bit target.
    function automatic logic [255:0] bits_to_target(input logic [31:0] nbits);
        int           size;
        logic [255:0] mant;
        size = int'(nbits[31:24]);
        mant = {233'd0, nbits[22:0]};
        if (size <= 3)
            return mant >> (8 * (3 - size));
        return mant << (8 * (size - 3));
    endfunction

    // Encode a 256-bit target into compact nBits form.
    function automatic logic [31:0] target_to_bits(input logic [255:0] v);
        int          width;
        int          size;
        logic [63:0] low;
        logic [31:0] c;
        width = 0;
        for (int i = 0; i < 256; i++)
            if (v[i])
                width = i + 1;
        size = (width + 7) / 8;
        if (size <= 3)
        begin
            low = v[63:0] << (8 * (3 - size));
            c = low[31:0];
        end
        else
            c = 32'(v >> (8 * (size - 3)));
        if (c[23])
        begin
            c = c >> 8;
            size++;
        end
        return {8'(size), c[23:0]};
    endfunction

    function automatic logic [255:0] quotient(input logic [255:0] v, input logic [63:0] d);
        if (d == 64'd0)
            return '1;
        return v / {192'd0, d};
    endfunction

    // Fold one header into the window; returns 1 when it closes the window.
    task automatic take_header(input logic [31:0] t, input logic [31:0] nbits,
                               input logic last, output logic done, output retarget_t r);
        logic [31:0]  st;
        logic [31:0]  st_max;
        logic [63:0]  n;
        logic [63:0]  k;
        logic [255:0] next;
        done = 1'b0;
        r = '0;
        if (count < WINDOW_CAP)
        begin
            if (count > 0)
            begin
                st = (t >= prev_time) ? t - prev_time : 32'd0;
                st_max = 32'd6 * {16'd0, spacing};
                if (st < 32'd1)
                    st = 32'd1;
                if (st > st_max)
                    st = st_max;
                weighted_st = weighted_st + {57'd0, count} * {32'd0, st};
            end
            target_total = target_total + bits_to_target(nbits);
            prev_time = t;
            count = count + 7'd1;
        end
        if (!last)
            return;
        done = 1'b1;
        n = {57'd0, count};
        if (n < {57'd0, min_headers})
            r = '{next_bits: 32'd0, status: 1'b1};
        else
        begin
            k = (n - 64'd1) * n / 64'd2;
            if (k == 64'd0)
                k = 64'd1;
            next = quotient(target_total, n);
            next = next * {192'd0, weighted_st};
            next = quotient(next, k * {48'd0, spacing});
            if (next > limit)
                next = limit;
            r = '{next_bits: target_to_bits(next), status: 1'b0};
        end
        prev_time = '0;
        count = '0;
        weighted_st = '0;
        target_total = '0;
    endtask

    // Track configuration, predict results and compare them.
    always @(posedge clk or negedge rst_n)
    begin
        logic      done;
        retarget_t r;
        retarget_t want;
        if (!rst_n)
        begin
            spacing = 16'd60;
            min_headers = 7'd45;
            limit = {64'h0000_0000_FFFF_FFFF, {192{1'b1}}};
            prev_time = '0;
            count = '0;
            weighted_st = '0;
            target_total = '0;
            retarget_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (retarget_q.size() == 0)
                begin
                    $error("unexpected result item: next_bits %h status %0d", m_tdata, m_tuser);
                    fail_count++;
                end
                else
                begin
                    want = retarget_q.pop_front();
                    if (m_tdata !== want.next_bits)
                    begin
                        $error("next_bits: expected %h, actual %h", want.next_bits, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                take_header(s_tdata[31:0], s_tdata[63:32], s_tlast, done, r);
                if (done)
                    retarget_q.push_back(r);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    lwr_pkg::REG_SPACING: spacing = cfg_data[15:0];
                    lwr_pkg::REG_MIN_WIN: min_headers = cfg_data[6:0];
                    lwr_pkg::REG_LIMIT0:  limit[63:0] = cfg_data;
                    lwr_pkg::REG_LIMIT1:  limit[127:64] = cfg_data;
                    lwr_pkg::REG_LIMIT2:  limit[191:128] = cfg_data;
                    lwr_pkg::REG_LIMIT3:  limit[255:192] = cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ----- tb/tb_lwma_difficulty_retarget_unit.sv -----
// Testbench top for the LWMA retarget unit: clock, reset, stimulus and verdict.
`default_nettype none

module tb_lwma_difficulty_retarget_unit;

    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // header_time [31:0], header_bits [63:32]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // next_bits [31:0]
    logic        m_tuser;    // status [0]
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          burst_left;
    bit          hold_req;
    logic [31:0] clock_sec;

    lwma_difficulty_retarget_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lwma_retarget_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_lwma_difficulty_retarget_unit: done, errors");
            $finish;
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off on request.
    initial
    begin
        int mode;
        int left;
        bit held;
        m_tready = 1'b0;
        mode = 0;
        left = 0;
        held = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            if (left == 0)
            begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(50, 400);
            end
            left--;
            case (mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                default: m_tready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Offer one header; after it is taken, keep s_tvalid up in a burst or drop it.
    task automatic send_header(input logic [31:0] t, input logic [31:0] nbits,
                               input logic last);
        s_tdata = {nbits, t};
        s_tlast = last;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(0, 40) : $urandom_range(0, 6))
                @(negedge clk);
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Let every result drain and the unit settle before touching registers.
    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] t, input logic [6:0] minw,
                              input logic [255:0] lim);
        write_reg(lwr_pkg::REG_SPACING, {48'd0, t});
        write_reg(lwr_pkg::REG_MIN_WIN, {57'd0, minw});
        write_reg(lwr_pkg::REG_LIMIT0, lim[63:0]);
        write_reg(lwr_pkg::REG_LIMIT1, lim[127:64]);
        write_reg(lwr_pkg::REG_LIMIT2, lim[191:128]);
        write_reg(lwr_pkg::REG_LIMIT3, lim[255:192]);
    endtask

    function automatic logic [31:0] random_bits();
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        return {8'($urandom_range(0, 34)), 24'($urandom)};
    endfunction

    function automatic logic [31:0] next_time(input logic [15:0] t);
        case ($urandom_range(0, 9))
            0: clock_sec = $urandom;
            1: clock_sec = clock_sec - $urandom_range(0, 500);
            default: clock_sec = clock_sec + $urandom_range(0, 7 * int'(t) + 2);
        endcase
        return clock_sec;
    endfunction

    // Random windows, mostly short, now and then past the window capacity.
    task automatic random_windows(input int count, input logic [15:0] t);
        int len;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(60, 70);
                1, 2, 3: len = $urandom_range(9, 66);
                default: len = $urandom_range(1, 8);
            endcase
            for (int i = 0; i < len; i++)
                send_header(next_time(t), random_bits(), i == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        logic [255:0] lim;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_req = 1'b0;
        burst_left = 0;
        clock_sec = 32'd1000;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // One default-length window under the reset configuration.
        for (int i = 0; i < 45; i++)
            send_header(32'd1000 + 32'(i * 60), 32'h1d00ffff, i == 44);
        wait_drained();

        // Directed windows: short window, backward time, huge gap, odd encodings.
        set_config(16'd60, 7'd2, {64'h0000_0000_FFFF_FFFF, {192{1'b1}}});
        send_header(32'd5, 32'h1d00ffff, 1'b1);
        send_header(32'd1000, 32'h1b04_8000 | 32'h0080_0000, 1'b0);
        send_header(32'd900, 32'h0300_0001, 1'b1);
        send_header(32'd0, 32'hFFFF_FFFF, 1'b0);
        send_header(32'hFFFF_FFFF, 32'h0000_0000, 1'b1);
        send_header(32'd100, 32'h0112_3456, 1'b0);
        send_header(32'd100, 32'h0212_3456, 1'b0);
        send_header(32'd160, 32'h2100_7fff, 1'b1);
        send_header(32'd0, 32'h2200_ffff, 1'b0);
        send_header(32'd1, 32'h20ff_ffff, 1'b1);
        wait_drained();

        // Long hold-off on the receiver while short windows keep arriving.
        set_config(16'd1, 7'd2, '1);
        hold_req = 1'b1;
        random_windows(40, 16'd1);
        random_windows(120, 16'd1);
        wait_drained();

        set_config(16'd1, 7'd64, '1);
        random_windows(130, 16'd1);
        wait_drained();

        lim = {192'd0, 64'($urandom) | 64'h1};
        set_config(16'd65535, 7'd2, lim);
        random_windows(120, 16'd65535);
        wait_drained();

        // Zero spacing: the second divide is by zero and the limit bounds the result.
        lim = {32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom),
               32'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
        set_config(16'd0, 7'd3, lim);
        random_windows(100, 16'd0);
        wait_drained();

        set_config(16'($urandom_range(1, 65535)), 7'($urandom_range(2, 64)),
                   {64'h0000_0000_FFFF_FFFF, {192{1'b1}}});
        random_windows(120, 16'd600);
        wait_drained();

        repeat (700) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_lwma_difficulty_retarget_unit: done, clean");
        else
            $display("tb_lwma_difficulty_retarget_unit: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

// ----- lwma_difficulty_retarget_unit.f -----
hw/rtl/lwr_pkg.sv
hw/rtl/lwr_ctrl.sv
hw/rtl/lwr_dp.sv
hw/rtl/lwma_difficulty_retarget_unit.sv
tb/lwma_retarget_checker.sv
tb/tb_lwma_difficulty_retarget_unit.sv
